>>> design/tads_pkg.sv
// Shared types and constants of the two-axis DDA step generator.
// Used by the channel interfaces, the slot engine, the top level and the checker.
package tads_pkg;

  localparam int ACCUM_WIDTH    = 16;
  localparam int POSITION_WIDTH = 16;
  localparam int INCR_WIDTH     = 16;
  localparam int TICK_WIDTH     = 16;
  localparam int POS_OUT_WIDTH  = 16;
  localparam int KIND_WIDTH     = 3;
  localparam int FREE_WIDTH     = 2;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_LOAD  = 3'd0,
    KIND_TICK  = 3'd1,
    KIND_START = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic [INCR_WIDTH-1:0] x_increment;
    logic [INCR_WIDTH-1:0] y_increment;
    logic                  x_forward;
    logic                  y_forward;
    logic [TICK_WIDTH-1:0] tick_count;
    logic                  starts_circle;
  } item_t;

  typedef struct packed {
    logic                            step_x;
    logic                            step_y;
    logic                            dir_x;
    logic                            dir_y;
    logic                            switched;
    logic                            circle_captured;
    logic                            underrun;
    logic                            load_accepted;
    logic                            running;
    logic signed [POS_OUT_WIDTH-1:0] position_x;
    logic signed [POS_OUT_WIDTH-1:0] position_y;
    logic [FREE_WIDTH-1:0]           free_slots;
  } result_t;

endpackage

>>> design/tads_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on tads_pkg for field widths.
interface tads_item_if;
  logic                                  valid;
  logic                                  ready;
  logic [tads_pkg::KIND_WIDTH-1:0]       kind;
  logic [tads_pkg::INCR_WIDTH-1:0]       x_increment;
  logic [tads_pkg::INCR_WIDTH-1:0]       y_increment;
  logic                                  x_forward;
  logic                                  y_forward;
  logic [tads_pkg::TICK_WIDTH-1:0]       tick_count;
  logic                                  starts_circle;

  modport source (
    output valid, kind, x_increment, y_increment, x_forward, y_forward,
           tick_count, starts_circle,
    input  ready
  );
  modport sink (
    input  valid, kind, x_increment, y_increment, x_forward, y_forward,
           tick_count, starts_circle,
    output ready
  );
endinterface

interface tads_result_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    step_x;
  logic                                    step_y;
  logic                                    dir_x;
  logic                                    dir_y;
  logic                                    switched;
  logic                                    circle_captured;
  logic                                    underrun;
  logic                                    load_accepted;
  logic                                    running;
  logic signed [tads_pkg::POS_OUT_WIDTH-1:0] position_x;
  logic signed [tads_pkg::POS_OUT_WIDTH-1:0] position_y;
  logic [tads_pkg::FREE_WIDTH-1:0]         free_slots;

  modport source (
    output valid, step_x, step_y, dir_x, dir_y, switched, circle_captured,
           underrun, load_accepted, running, position_x, position_y, free_slots,
    input  ready
  );
  modport sink (
    input  valid, step_x, step_y, dir_x, dir_y, switched, circle_captured,
           underrun, load_accepted, running, position_x, position_y, free_slots,
    output ready
  );
endinterface

>>> design/tads_engine.sv
// Segment slots, accumulators, position counters and run control.
// Applies one command item per enabled cycle; depends on tads_pkg.
module tads_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tads_pkg::item_t   item_i,
  output tads_pkg::result_t result_o
);

  localparam int AW = tads_pkg::ACCUM_WIDTH;
  localparam int PW = tads_pkg::POSITION_WIDTH;
  localparam int TW = tads_pkg::TICK_WIDTH;

  // control and architectural state, cleared at reset
  logic [AW-1:0] x_acc_q [2];
  logic [AW-1:0] x_acc_d [2];
  logic [AW-1:0] y_acc_q [2];
  logic [AW-1:0] y_acc_d [2];
  logic [1:0]    full_q, full_d;
  logic          active_q, active_d;
  logic          enabled_q, enabled_d;
  logic [PW-1:0] net_x_q, net_x_d;
  logic [PW-1:0] net_y_q, net_y_d;

  // segment payload, undefined until loaded
  logic [AW-1:0] x_inc_q [2];
  logic [AW-1:0] y_inc_q [2];
  logic [1:0]    x_fwd_q, y_fwd_q, circ_q;
  logic [TW-1:0] ticks_q [2];

  logic          load_we;
  logic          load_slot;
  logic          tick_we;
  logic [TW-1:0] ticks_dec;
  logic [AW-1:0] sum_x, sum_y;
  logic          a, b;

  always_comb begin
    a         = active_q;
    b         = ~active_q;
    x_acc_d   = x_acc_q;
    y_acc_d   = y_acc_q;
    full_d    = full_q;
    active_d  = active_q;
    enabled_d = enabled_q;
    net_x_d   = net_x_q;
    net_y_d   = net_y_q;
    load_we   = 1'b0;
    load_slot = full_q[0];
    tick_we   = 1'b0;
    sum_x     = x_acc_q[a] + x_inc_q[a];
    sum_y     = y_acc_q[a] + y_inc_q[a];
    ticks_dec = ticks_q[a] - TW'(1);
    result_o  = '0;

    case (tads_pkg::kind_e'(item_i.kind))
      tads_pkg::KIND_LOAD: begin
        if (!full_q[0] || !full_q[1]) begin
          load_we              = 1'b1;
          x_acc_d[load_slot]   = '0;
          y_acc_d[load_slot]   = '0;
          full_d[load_slot]    = 1'b1;
          result_o.load_accepted = 1'b1;
        end
      end
      tads_pkg::KIND_TICK: begin
        if (enabled_q) begin
          tick_we = 1'b1;
          // step on the top bit, then drop it
          x_acc_d[a] = {1'b0, sum_x[AW-2:0]};
          y_acc_d[a] = {1'b0, sum_y[AW-2:0]};
          if (sum_x[AW-1]) begin
            result_o.step_x = 1'b1;
            net_x_d = x_fwd_q[a] ? net_x_q + PW'(1) : net_x_q - PW'(1);
          end
          if (sum_y[AW-1]) begin
            result_o.step_y = 1'b1;
            net_y_d = y_fwd_q[a] ? net_y_q + PW'(1) : net_y_q - PW'(1);
          end
          if (ticks_dec == '0) begin
            if (full_q[b]) begin
              result_o.circle_captured = circ_q[b];
              full_d[a]                = 1'b0;
              active_d                 = b;
              result_o.switched        = 1'b1;
            end else begin
              enabled_d         = 1'b0;
              result_o.underrun = 1'b1;
            end
          end
        end
      end
      tads_pkg::KIND_START: enabled_d = 1'b1;
      tads_pkg::KIND_STOP:  enabled_d = 1'b0;
      tads_pkg::KIND_CLEAR: begin
        full_d   = '0;
        x_acc_d  = '{default: '0};
        y_acc_d  = '{default: '0};
        net_x_d  = '0;
        net_y_d  = '0;
        active_d = 1'b0;
      end
      default: ;
    endcase

    // status after the item, seen from the slot now active
    if (full_d[active_d]) begin
      result_o.dir_x = (load_we && load_slot == active_d) ?
                       item_i.x_forward : x_fwd_q[active_d];
      result_o.dir_y = (load_we && load_slot == active_d) ?
                       item_i.y_forward : y_fwd_q[active_d];
    end
    result_o.running    = enabled_d;
    result_o.position_x = tads_pkg::POS_OUT_WIDTH'($signed(net_x_d));
    result_o.position_y = tads_pkg::POS_OUT_WIDTH'($signed(net_y_d));
    result_o.free_slots = {1'b0, ~full_d[0]} + {1'b0, ~full_d[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q   <= '{default: '0};
      y_acc_q   <= '{default: '0};
      full_q    <= '0;
      active_q  <= 1'b0;
      enabled_q <= 1'b0;
      net_x_q   <= '0;
      net_y_q   <= '0;
    end else if (fire_i) begin
      x_acc_q   <= x_acc_d;
      y_acc_q   <= y_acc_d;
      full_q    <= full_d;
      active_q  <= active_d;
      enabled_q <= enabled_d;
      net_x_q   <= net_x_d;
      net_y_q   <= net_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && load_we) begin
      x_inc_q[load_slot]   <= AW'(item_i.x_increment);
      y_inc_q[load_slot]   <= AW'(item_i.y_increment);
      x_fwd_q[load_slot]   <= item_i.x_forward;
      y_fwd_q[load_slot]   <= item_i.y_forward;
      circ_q[load_slot]    <= item_i.starts_circle;
      ticks_q[load_slot]   <= item_i.tick_count;
    end else if (fire_i && tick_we) begin
      ticks_q[a] <= ticks_dec;
    end
  end

endmodule

>>> design/two_axis_dda_step_generator.sv
// Two-axis DDA step generator: top level with item register and result register.
// Depends on tads_pkg, tads_if and tads_engine.
//
// Usage
//   item_i carries commands: load a segment into a free slot, tick, start,
//   stop, or clear slots and counters. Every command transaction yields
//   exactly one result transaction on result_o with step pulses, directions,
//   slot switch, circle capture, underrun, load status, run flag, net
//   positions and the free slot count.
//   The item sits in the item register while the slot engine works out the
//   status; once the result register is free or being drained, the engine
//   updates its state and the result register captures the status.
//   Throughput is one item per cycle while the receiver takes results; the
//   engine's single add/compare pass per tick sets that figure.
//   While the receiver stalls, the finished result is held in the result
//   register and one further item may wait in the item register; item_i
//   deasserts ready only once both are occupied.
//   Reset empties both slots, selects slot 0, stops the block and zeroes the
//   accumulators and positions. Segment contents stay undefined until loaded.
module two_axis_dda_step_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  tads_item_if.sink     item_i,
  tads_result_if.source result_o
);

  logic              in_valid_q;
  tads_pkg::item_t   in_q;
  logic              out_valid_q;
  tads_pkg::result_t out_q;
  tads_pkg::result_t res;
  logic              adv;
  logic              in_ready;

  // advance when the result register is free or being drained
  assign adv      = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !in_valid_q || adv;
  assign item_i.ready = in_ready;

  tads_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (adv),
    .item_i   (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= item_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      in_q.kind          <= item_i.kind;
      in_q.x_increment   <= item_i.x_increment;
      in_q.y_increment   <= item_i.y_increment;
      in_q.x_forward     <= item_i.x_forward;
      in_q.y_forward     <= item_i.y_forward;
      in_q.tick_count    <= item_i.tick_count;
      in_q.starts_circle <= item_i.starts_circle;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.step_x          = out_q.step_x;
  assign result_o.step_y          = out_q.step_y;
  assign result_o.dir_x           = out_q.dir_x;
  assign result_o.dir_y           = out_q.dir_y;
  assign result_o.switched        = out_q.switched;
  assign result_o.circle_captured = out_q.circle_captured;
  assign result_o.underrun        = out_q.underrun;
  assign result_o.load_accepted   = out_q.load_accepted;
  assign result_o.running         = out_q.running;
  assign result_o.position_x      = out_q.position_x;
  assign result_o.position_y      = out_q.position_y;
  assign result_o.free_slots      = out_q.free_slots;

endmodule

>>> design/tads_checker.sv
// Port-level checker for the step generator, bound to the top level.
// Depends on tads_pkg for widths.
module tads_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     out_valid_i,
  input logic                                     out_ready_i,
  input logic                                     switched_i,
  input logic                                     circle_captured_i,
  input logic                                     underrun_i,
  input logic                                     load_accepted_i,
  input logic                                     running_i,
  input logic                                     step_x_i,
  input logic signed [tads_pkg::POS_OUT_WIDTH-1:0] position_x_i,
  input logic [tads_pkg::FREE_WIDTH-1:0]          free_slots_i
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(position_x_i)
      && $stable(free_slots_i))
    else $error("stalled result changed");

  // underrun stops the block and never coincides with a switch
  a_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && underrun_i |-> !running_i && !switched_i)
    else $error("underrun with block still running or switching");

  // capture only happens on a slot switch, and a switch frees a slot
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && circle_captured_i |-> switched_i && free_slots_i != 2'd0)
    else $error("circle capture without slot switch");

  // an accepted load leaves at most one free slot and emits no step
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && load_accepted_i |-> free_slots_i != 2'd2 && !step_x_i)
    else $error("load status inconsistent");

endmodule

bind two_axis_dda_step_generator tads_checker u_tads_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .switched_i        (result_o.switched),
  .circle_captured_i (result_o.circle_captured),
  .underrun_i        (result_o.underrun),
  .load_accepted_i   (result_o.load_accepted),
  .running_i         (result_o.running),
  .step_x_i          (result_o.step_x),
  .position_x_i      (result_o.position_x),
  .free_slots_i      (result_o.free_slots)
);

>>> verif/tb_two_axis_dda_step_generator.sv
// Self-checking bench for the two-axis DDA step generator: directed and random commands.
// Checks every status transaction against an in-bench slot/accumulator predictor.
// Depends on tads_pkg, tads_if and the two_axis_dda_step_generator top level.
`timescale 1ns / 100ps

module tb_two_axis_dda_step_generator;
  import tads_pkg::*;

  localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_LEN     = 90;
  localparam int TX_QUIET_LO  = 1300;
  localparam int TX_QUIET_HI  = 1650;
  localparam int RX_QUIET_LO  = 1350;
  localparam int RX_QUIET_HI  = 1700;
  localparam int DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  tads_item_if   item_ch ();
  tads_result_if status_ch ();

  two_axis_dda_step_generator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (status_ch)
  );

  // Predictor state: two segment slots plus the shared counters
  logic [ACCUM_WIDTH-1:0]    x_acc [2];
  logic [ACCUM_WIDTH-1:0]    y_acc [2];
  logic [ACCUM_WIDTH-1:0]    seg_x_inc [2];
  logic [ACCUM_WIDTH-1:0]    seg_y_inc [2];
  logic                      seg_x_fwd [2];
  logic                      seg_y_fwd [2];
  logic [TICK_WIDTH-1:0]     seg_ticks [2];
  logic                      seg_circle [2];
  logic                      seg_full [2];
  logic                      live_slot;
  logic                      run_en;
  logic [POSITION_WIDTH-1:0] pos_x;
  logic [POSITION_WIDTH-1:0] pos_y;

  item_t   pending_cmds [$];
  result_t expected_status [$];

  logic item_taken;
  int   tx_cycle;
  int   rx_cycle;
  int   hold_left;
  int   mismatches;
  int   n_status, n_steps, n_switches, n_captures, n_underruns, n_loads;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic result_t step_status(item_t it);
    result_t want;
    logic    a;
    logic    b;
    logic    s;
    want = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (!seg_full[0] || !seg_full[1]) begin
          s = seg_full[0];
          seg_x_inc[s]  = it.x_increment;
          seg_y_inc[s]  = it.y_increment;
          seg_x_fwd[s]  = it.x_forward;
          seg_y_fwd[s]  = it.y_forward;
          seg_ticks[s]  = it.tick_count;
          seg_circle[s] = it.starts_circle;
          x_acc[s]      = '0;
          y_acc[s]      = '0;
          seg_full[s]   = 1'b1;
          want.load_accepted = 1'b1;
        end
      end
      KIND_TICK: begin
        if (run_en) begin
          a = live_slot;
          b = ~live_slot;
          x_acc[a] = x_acc[a] + seg_x_inc[a];
          y_acc[a] = y_acc[a] + seg_y_inc[a];
          if (x_acc[a][ACCUM_WIDTH-1]) begin
            want.step_x = 1'b1;
            pos_x = seg_x_fwd[a] ? pos_x + 1'b1 : pos_x - 1'b1;
            x_acc[a][ACCUM_WIDTH-1] = 1'b0;
          end
          if (y_acc[a][ACCUM_WIDTH-1]) begin
            want.step_y = 1'b1;
            pos_y = seg_y_fwd[a] ? pos_y + 1'b1 : pos_y - 1'b1;
            y_acc[a][ACCUM_WIDTH-1] = 1'b0;
          end
          seg_ticks[a] = seg_ticks[a] - 1'b1;
          if (seg_ticks[a] == '0) begin
            if (seg_full[b]) begin
              want.circle_captured = seg_circle[b];
              seg_full[a] = 1'b0;
              live_slot   = b;
              want.switched = 1'b1;
            end else begin
              run_en = 1'b0;
              want.underrun = 1'b1;
            end
          end
        end
      end
      KIND_START: run_en = 1'b1;
      KIND_STOP:  run_en = 1'b0;
      KIND_CLEAR: begin
        // keep the slot contents, empty the slots and zero the counters
        seg_full  = '{1'b0, 1'b0};
        x_acc     = '{'0, '0};
        y_acc     = '{'0, '0};
        pos_x     = '0;
        pos_y     = '0;
        live_slot = 1'b0;
      end
      default: ;
    endcase
    want.dir_x      = seg_full[live_slot] ? seg_x_fwd[live_slot] : 1'b0;
    want.dir_y      = seg_full[live_slot] ? seg_y_fwd[live_slot] : 1'b0;
    want.running    = run_en;
    want.position_x = pos_x;
    want.position_y = pos_y;
    want.free_slots = {1'b0, !seg_full[0]} + {1'b0, !seg_full[1]};
    return want;
  endfunction

  function automatic item_t make_item(logic [KIND_WIDTH-1:0] kind,
                                      logic [INCR_WIDTH-1:0] x_inc, logic [INCR_WIDTH-1:0] y_inc,
                                      logic x_fwd, logic y_fwd,
                                      logic [TICK_WIDTH-1:0] ticks, logic circle);
    item_t it;
    it.kind          = kind;
    it.x_increment   = x_inc;
    it.y_increment   = y_inc;
    it.x_forward     = x_fwd;
    it.y_forward     = y_fwd;
    it.tick_count    = ticks;
    it.starts_circle = circle;
    return it;
  endfunction

  function automatic logic [INCR_WIDTH-1:0] random_increment();
    int r;
    r = $urandom_range(99);
    if (r < 10) return INCR_WIDTH'($urandom);
    if (r < 16) return 16'h8000;
    if (r < 22) return '0;
    return INCR_WIDTH'($urandom_range(32768));
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: offer commands at the falling edge, hold each until its transaction
  always @(posedge clk_i) begin
    item_taken <= item_ch.valid && item_ch.ready;
    if (item_ch.valid && item_ch.ready)
      expected_status.push_back(step_status(make_item(item_ch.kind, item_ch.x_increment,
        item_ch.y_increment, item_ch.x_forward, item_ch.y_forward, item_ch.tick_count,
        item_ch.starts_circle)));
  end

  always @(negedge clk_i) begin
    item_t it;
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
    end else begin
      tx_cycle <= tx_cycle + 1;
      if (!item_ch.valid || item_taken) begin
        if (pending_cmds.size() != 0 &&
            ((tx_cycle >= TX_QUIET_LO && tx_cycle < TX_QUIET_HI) ||
             $urandom_range(99) >= 33)) begin
          it = pending_cmds.pop_front();
          item_ch.kind          <= it.kind;
          item_ch.x_increment   <= it.x_increment;
          item_ch.y_increment   <= it.y_increment;
          item_ch.x_forward     <= it.x_forward;
          item_ch.y_forward     <= it.y_forward;
          item_ch.tick_count    <= it.tick_count;
          item_ch.starts_circle <= it.starts_circle;
          item_ch.valid         <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off to fill the pipeline
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      status_ch.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == HOLD_AT) begin
        hold_left       <= HOLD_LEN;
        status_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI) ||
                           ($urandom_range(99) >= 33);
      end
    end
  end

  // Monitor: compare each status transaction with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (status_ch.valid && status_ch.ready) begin
      if (expected_status.size() == 0) begin
        $error("status transaction with no command outstanding");
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("step_x", want.step_x, status_ch.step_x);
        check_field("step_y", want.step_y, status_ch.step_y);
        check_field("dir_x", want.dir_x, status_ch.dir_x);
        check_field("dir_y", want.dir_y, status_ch.dir_y);
        check_field("switched", want.switched, status_ch.switched);
        check_field("circle_captured", want.circle_captured, status_ch.circle_captured);
        check_field("underrun", want.underrun, status_ch.underrun);
        check_field("load_accepted", want.load_accepted, status_ch.load_accepted);
        check_field("running", want.running, status_ch.running);
        check_field("position_x", want.position_x, status_ch.position_x);
        check_field("position_y", want.position_y, status_ch.position_y);
        check_field("free_slots", want.free_slots, status_ch.free_slots);
        n_status++;
        n_steps     += want.step_x + want.step_y;
        n_switches  += want.switched;
        n_captures  += want.circle_captured;
        n_underruns += want.underrun;
        n_loads     += want.load_accepted;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_two_axis_dda_step_generator: done, errors");
    $finish;
  end

  initial begin
    int r;
    logic [KIND_WIDTH-1:0] k;
    rst_ni      = 1'b0;
    item_taken  = 1'b0;
    tx_cycle    = 0;
    rx_cycle    = 0;
    hold_left   = 0;
    mismatches  = 0;
    n_status    = 0;
    n_steps     = 0;
    n_switches  = 0;
    n_captures  = 0;
    n_underruns = 0;
    n_loads     = 0;
    item_ch.valid         = 1'b0;
    item_ch.kind          = KIND_STOP;
    item_ch.x_increment   = '0;
    item_ch.y_increment   = '0;
    item_ch.x_forward     = 1'b0;
    item_ch.y_forward     = 1'b0;
    item_ch.tick_count    = '0;
    item_ch.starts_circle = 1'b0;
    status_ch.ready       = 1'b0;

    // Unwritten slot entries read as zero
    x_acc      = '{'0, '0};
    y_acc      = '{'0, '0};
    seg_x_inc  = '{'0, '0};
    seg_y_inc  = '{'0, '0};
    seg_x_fwd  = '{1'b0, 1'b0};
    seg_y_fwd  = '{1'b0, 1'b0};
    seg_ticks  = '{'0, '0};
    seg_circle = '{1'b0, 1'b0};
    seg_full   = '{1'b0, 1'b0};
    live_slot  = 1'b0;
    run_en     = 1'b0;
    pos_x      = '0;
    pos_y      = '0;

    // Directed: tick while stopped, fill both slots, load with no room, unused kinds
    pending_cmds.push_back(make_item(KIND_TICK, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_LOAD, 16'h8000, '0, 1'b1, 1'b0, 16'd2, 1'b0));
    pending_cmds.push_back(make_item(KIND_LOAD, 16'h4000, 16'h8000, 1'b0, 1'b1, 16'd1, 1'b1));
    pending_cmds.push_back(make_item(KIND_LOAD, '1, '1, 1'b1, 1'b1, '1, 1'b1));
    for (k = KIND_UNUSED_LO; k != KIND_UNUSED_HI; k++)
      pending_cmds.push_back(make_item(k, '1, '1, 1'b1, 1'b1, '1, 1'b1));
    pending_cmds.push_back(make_item(KIND_UNUSED_HI, '1, '1, 1'b1, 1'b1, '1, 1'b1));
    // run through a switch with circle capture into an underrun, then restart it
    pending_cmds.push_back(make_item(KIND_START, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    repeat (3) pending_cmds.push_back(make_item(KIND_TICK, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_START, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_TICK, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_STOP, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_TICK, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_CLEAR, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    // zero tick count with oversized increments, then zero increments with the largest tick count
    pending_cmds.push_back(make_item(KIND_LOAD, '1, 16'h8001, 1'b1, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_LOAD, '0, '0, 1'b0, 1'b0, '1, 1'b1));
    pending_cmds.push_back(make_item(KIND_START, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    repeat (3) pending_cmds.push_back(make_item(KIND_TICK, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_STOP, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    pending_cmds.push_back(make_item(KIND_CLEAR, '0, '0, 1'b0, 1'b0, '0, 1'b0));

    // Random: mostly loads and ticks on short segments; ignored fields carry noise
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 15)      k = KIND_LOAD;
      else if (r < 86) k = KIND_TICK;
      else if (r < 92) k = KIND_START;
      else if (r < 95) k = KIND_STOP;
      else if (r < 97) k = KIND_CLEAR;
      else             k = KIND_WIDTH'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      r = $urandom_range(99);
      pending_cmds.push_back(make_item(k, random_increment(), random_increment(),
        1'($urandom), 1'($urandom),
        (r < 4) ? TICK_WIDTH'($urandom) : TICK_WIDTH'($urandom_range(12, 1)),
        1'($urandom)));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || item_ch.valid) @(posedge clk_i);
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d status transactions: %0d segment loads, %0d steps,", n_status,
             n_loads, n_steps);
    $display("  %0d slot switches, %0d circle captures, %0d underruns", n_switches,
             n_captures, n_underruns);
    if (mismatches == 0)
      $display("tb_two_axis_dda_step_generator: done, clean");
    else
      $display("tb_two_axis_dda_step_generator: done, errors");
    $finish;
  end

endmodule

>>> sim.f
design/tads_pkg.sv
design/tads_if.sv
design/tads_engine.sv
design/two_axis_dda_step_generator.sv
design/tads_checker.sv
verif/tb_two_axis_dda_step_generator.sv
